FILE: hdl/cftf_pkg.sv
// Package for the chase, cross-fade and sparkle frame generator.
// Holds sizes, constants, register indexes, payload structs and controller types.
// No dependencies.
package cftf_pkg;

   localparam int PIXELS         = 32;
   localparam int SPARKLE_SLOTS  = 6;
   localparam int PIX_W          = 5;
   localparam int COLOR_W        = 8;
   localparam int FADE_W         = 11;
   localparam int FRAC_W         = 10;
   localparam int FADE_ONE       = 1024;
   localparam int ROLL_W         = 7;
   localparam int SPAWN_LIMIT    = 10;
   localparam int SPARKLE_START  = 127;
   localparam int SPARKLE_DECAY  = 8;
   localparam int SPARKLE_RETIRE = 15;
   localparam int PROD_W         = COLOR_W + FADE_W;

   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_RED_LEVEL   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_LEVEL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_STEP   = 2'd2;

   localparam logic [COLOR_W-1:0] RED_LEVEL_RESET   = 8'd127;
   localparam logic [COLOR_W-1:0] GREEN_LEVEL_RESET = 8'd127;
   localparam logic [FADE_W-1:0]  FADE_STEP_RESET   = 11'd20;

   typedef struct packed {
      logic [ROLL_W-1:0] spawn_roll;
      logic [PIX_W-1:0]  spawn_pixel;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel_index;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic               frame_end;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SCALE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic update;
      logic scale;
      logic load;
      logic flip;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

endpackage

FILE: hdl/cftf_ctrl.sv
// Controller for the frame generator: sequences capture, update, scale and pixel output.
// Depends on cftf_pkg.
module cftf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cftf_pkg::cmd_type    cmd,
   input  cftf_pkg::status_type status
);

   cftf_pkg::state_type state_ff, state_in;
   logic valid_ff, valid_in;
   logic done_ff, done_in;
   logic fire;
   logic can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cftf_pkg::ST_IDLE;
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         done_ff  <= done_in;
      end
   end

   assign fire     = valid_ff && rsp_ready;
   assign can_load = !valid_ff || fire;

   always_comb begin
      state_in   = state_ff;
      valid_in   = valid_ff;
      done_in    = done_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         cftf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = cftf_pkg::ST_UPDATE;
            end
         end
         cftf_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = cftf_pkg::ST_SCALE;
         end
         cftf_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            done_in   = 1'b0;
            state_in  = cftf_pkg::ST_EMIT;
         end
         cftf_pkg::ST_EMIT: begin
            if (can_load && !done_ff) begin
               cmd.load = 1'b1;
               valid_in = 1'b1;
               done_in  = status.last;
            end else if (fire) begin
               valid_in = 1'b0;
               // The final pixel has been taken, so the frame is complete.
               if (done_ff) begin
                  cmd.flip = 1'b1;
                  done_in  = 1'b0;
                  state_in = cftf_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = cftf_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = valid_ff;

   a_valid_in_emit: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> state_ff == cftf_pkg::ST_EMIT)
      else $error("result valid outside the output phase");

   a_last_sets_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && status.last) |=> done_ff && valid_ff)
      else $error("last pixel load did not mark the frame done");

   a_frame_closes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cftf_pkg::ST_EMIT && done_ff && fire) |=>
         state_ff == cftf_pkg::ST_IDLE && !valid_ff)
      else $error("frame did not close after the final transaction");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != cftf_pkg::ST_IDLE) |-> !cmd.start)
      else $error("input captured while a frame is in progress");

endmodule

FILE: hdl/cftf_dp.sv
// Datapath for the frame generator: settings, fade state, sparkle slots and output register.
// Depends on cftf_pkg.
module cftf_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  cftf_pkg::req_type                 req_data,
   input  logic                              csr_valid,
   input  logic [cftf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cftf_pkg::CSR_DATA_W-1:0]   csr_data,
   input  cftf_pkg::cmd_type                 cmd,
   output cftf_pkg::status_type              status,
   output cftf_pkg::rsp_type                 rsp_data
);

   localparam int N = cftf_pkg::SPARKLE_SLOTS;

   logic [cftf_pkg::COLOR_W-1:0] red_level_ff;
   logic [cftf_pkg::COLOR_W-1:0] green_level_ff;
   logic [cftf_pkg::FADE_W-1:0]  fade_step_ff;

   cftf_pkg::req_type             item_ff;
   logic [cftf_pkg::FADE_W-1:0]  fade_level_ff, fade_level_in;
   logic                         toward_green_ff, toward_green_in;
   logic                         chase_ff;

   logic [N-1:0]                 active_ff, active_in;
   logic [N-1:0]                 lit_ff, lit_in;
   logic [cftf_pkg::PIX_W-1:0]   spix_ff [N];
   logic [cftf_pkg::COLOR_W-1:0] slevel_ff [N];
   logic [cftf_pkg::COLOR_W-1:0] slevel_in [N];
   logic [N-1:0]                 spawn_sel;

   logic [cftf_pkg::COLOR_W-1:0] red_val_ff, green_val_ff;
   logic [cftf_pkg::PROD_W-1:0]  red_prod, green_prod;
   logic [cftf_pkg::FADE_W-1:0]  fade_inv;
   logic [cftf_pkg::FADE_W:0]    fade_sum;

   logic [cftf_pkg::PIX_W-1:0]   cnt_ff;
   cftf_pkg::rsp_type             rsp_ff, pixel;

   // Register port; an index past the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         red_level_ff   <= cftf_pkg::RED_LEVEL_RESET;
         green_level_ff <= cftf_pkg::GREEN_LEVEL_RESET;
         fade_step_ff   <= cftf_pkg::FADE_STEP_RESET;
      end else if (csr_valid) begin
         if (csr_index == cftf_pkg::CSR_RED_LEVEL) begin
            red_level_ff <= csr_data[cftf_pkg::COLOR_W-1:0];
         end
         if (csr_index == cftf_pkg::CSR_GREEN_LEVEL) begin
            green_level_ff <= csr_data[cftf_pkg::COLOR_W-1:0];
         end
         if (csr_index == cftf_pkg::CSR_FADE_STEP) begin
            fade_step_ff <= csr_data[cftf_pkg::FADE_W-1:0];
         end
      end
   end

   // The spawn goes to the lowest free slot.
   always_comb begin
      logic found;
      found     = 1'b0;
      spawn_sel = '0;
      for (int s = 0; s < N; s++) begin
         if (!active_ff[s] && !found) begin
            spawn_sel[s] = 1'b1;
            found        = 1'b1;
         end
      end
   end

   assign fade_sum = {1'b0, fade_level_ff} + {1'b0, fade_step_ff};

   always_comb begin
      fade_level_in   = fade_level_ff;
      toward_green_in = toward_green_ff;
      if (toward_green_ff) begin
         if (fade_step_ff >= fade_level_ff) begin
            fade_level_in   = '0;
            toward_green_in = 1'b0;
         end else begin
            fade_level_in = fade_level_ff - fade_step_ff;
         end
      end else begin
         if (fade_sum >= (cftf_pkg::FADE_W+1)'(cftf_pkg::FADE_ONE)) begin
            fade_level_in   = cftf_pkg::FADE_W'(cftf_pkg::FADE_ONE);
            toward_green_in = 1'b1;
         end else begin
            fade_level_in = fade_sum[cftf_pkg::FADE_W-1:0];
         end
      end
   end

   assign fade_inv   = cftf_pkg::FADE_W'(cftf_pkg::FADE_ONE) - fade_level_ff;
   assign red_prod   = cftf_pkg::PROD_W'(red_level_ff) * cftf_pkg::PROD_W'(fade_level_ff);
   assign green_prod = cftf_pkg::PROD_W'(green_level_ff) * cftf_pkg::PROD_W'(fade_inv);

   // Sparkle decay: a lit sparkle has already dropped by one step this frame.
   always_comb begin
      for (int s = 0; s < N; s++) begin
         active_in[s] = active_ff[s];
         lit_in[s]    = 1'b0;
         slevel_in[s] = slevel_ff[s];
         if (active_ff[s]) begin
            if (slevel_ff[s] > cftf_pkg::COLOR_W'(cftf_pkg::SPARKLE_RETIRE)) begin
               slevel_in[s] = slevel_ff[s] - cftf_pkg::COLOR_W'(cftf_pkg::SPARKLE_DECAY);
               lit_in[s]    = 1'b1;
            end else begin
               active_in[s] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_level_ff   <= cftf_pkg::FADE_W'(cftf_pkg::FADE_ONE);
         toward_green_ff <= 1'b1;
         chase_ff        <= 1'b0;
         active_ff       <= '0;
         lit_ff          <= '0;
      end else begin
         if (cmd.update) begin
            fade_level_ff   <= fade_level_in;
            toward_green_ff <= toward_green_in;
            if (item_ff.spawn_roll < cftf_pkg::ROLL_W'(cftf_pkg::SPAWN_LIMIT)) begin
               active_ff <= active_ff | spawn_sel;
            end
         end
         if (cmd.scale) begin
            active_ff <= active_in;
            lit_ff    <= lit_in;
         end
         if (cmd.flip) begin
            chase_ff <= !chase_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         item_ff <= req_data;
      end
      for (int s = 0; s < N; s++) begin
         if (cmd.update && spawn_sel[s] &&
             item_ff.spawn_roll < cftf_pkg::ROLL_W'(cftf_pkg::SPAWN_LIMIT)) begin
            spix_ff[s]   <= item_ff.spawn_pixel;
            slevel_ff[s] <= cftf_pkg::COLOR_W'(cftf_pkg::SPARKLE_START);
         end else if (cmd.scale) begin
            slevel_ff[s] <= slevel_in[s];
         end
      end
      if (cmd.scale) begin
         red_val_ff   <= red_prod[cftf_pkg::FRAC_W +: cftf_pkg::COLOR_W];
         green_val_ff <= green_prod[cftf_pkg::FRAC_W +: cftf_pkg::COLOR_W];
      end
      if (cmd.load) begin
         rsp_ff <= pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.scale) begin
         cnt_ff <= '0;
      end else if (cmd.load) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign status.last = (cnt_ff == cftf_pkg::PIX_W'(cftf_pkg::PIXELS - 1));

   // Base chase color, then sparkles in slot order so a later slot wins.
   always_comb begin
      pixel.pixel_index = cnt_ff;
      pixel.frame_end   = status.last;
      pixel.blue        = '0;
      if (cnt_ff[0] == chase_ff) begin
         pixel.red   = red_val_ff;
         pixel.green = '0;
      end else begin
         pixel.red   = '0;
         pixel.green = green_val_ff;
      end
      for (int s = 0; s < N; s++) begin
         if (lit_ff[s] && spix_ff[s] == cnt_ff) begin
            pixel.red   = slevel_ff[s];
            pixel.green = slevel_ff[s];
            pixel.blue  = slevel_ff[s];
         end
      end
   end

   assign rsp_data = rsp_ff;

   a_fade_in_range: assert property (@(posedge clock) disable iff (reset)
      fade_level_ff <= cftf_pkg::FADE_W'(cftf_pkg::FADE_ONE))
      else $error("fade level beyond full scale");

   a_lit_is_active: assert property (@(posedge clock) disable iff (reset)
      cmd.scale |=> (lit_ff & ~active_ff) == '0)
      else $error("sparkle shown from a retired slot");

   a_count_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.scale |=> cnt_ff == '0)
      else $error("pixel count not cleared for a new frame");

endmodule

FILE: hdl/chase_fade_twinkle_frame.sv
// Top level of the chase, cross-fade and sparkle frame generator.
// Depends on cftf_pkg, cftf_ctrl and cftf_dp.
//
//   channel  | ports                                  | direction
//   ---------+----------------------------------------+----------
//   request  | req_valid, req_ready, req_data         | in
//   response | rsp_valid, rsp_ready, rsp_data         | out
//   csr      | csr_valid, csr_ready, csr_index/data   | in
//
// One request transaction yields 32 response transactions, one per pixel in order.
// A frame starts with setup (capture, spawn and fade, multiply and decay) and
// then outputs one pixel per cycle through the output register unless stalled.
// The next request is accepted in the cycle after the last pixel is taken.
// A stalled response holds the output register; the next request waits for the frame.
// Reset is synchronous; settings return to their defaults and all sparkles clear.
module chase_fade_twinkle_frame (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  cftf_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output cftf_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cftf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cftf_pkg::CSR_DATA_W-1:0]  csr_data
);

   cftf_pkg::cmd_type    cmd;
   cftf_pkg::status_type status;

   assign csr_ready = 1'b1;

   cftf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   cftf_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
